### rtl/imbe_fdd_pkg.sv
// Shared types, constants and the interleave table of the IMBE frame deinterleaver.
package imbe_fdd_pkg;

    localparam int FRAME_BITS  = 144;
    localparam int FIELD_BITS  = 48;
    localparam int LCG_BITS    = 16;
    localparam int C0_BITS     = 12;
    localparam int C7_BITS     = 7;
    localparam int WIN_FIRST   = 23;
    localparam int WIN_BITS    = 114;
    localparam int NUM_CELLS   = WIN_BITS;

    localparam logic [LCG_BITS-1:0] LCG_MUL = 16'd173;
    localparam logic [LCG_BITS-1:0] LCG_ADD = 16'd13849;

    // Data carried from cell to cell: generator state, the window that is being
    // descrambled, and the two vectors that pass through untouched.
    typedef struct packed {
        logic [LCG_BITS-1:0] lcg;
        logic [WIN_BITS-1:0] win;
        logic [C0_BITS-1:0]  c0;
        logic [C7_BITS-1:0]  c7;
    } cell_data_t;

    typedef logic [7:0] ilv_entry_t;

    localparam ilv_entry_t ILV [FRAME_BITS] = '{
        8'd0,   8'd7,   8'd12,  8'd19,  8'd24,  8'd31,  8'd36,  8'd43,
        8'd48,  8'd55,  8'd60,  8'd67,  8'd72,  8'd79,  8'd84,  8'd91,
        8'd96,  8'd103, 8'd108, 8'd115, 8'd120, 8'd127, 8'd132, 8'd139,
        8'd1,   8'd6,   8'd13,  8'd18,  8'd25,  8'd30,  8'd37,  8'd42,
        8'd49,  8'd54,  8'd61,  8'd66,  8'd73,  8'd78,  8'd85,  8'd90,
        8'd97,  8'd102, 8'd109, 8'd114, 8'd121, 8'd126, 8'd133, 8'd138,
        8'd2,   8'd9,   8'd14,  8'd21,  8'd26,  8'd33,  8'd38,  8'd45,
        8'd50,  8'd57,  8'd62,  8'd69,  8'd74,  8'd81,  8'd86,  8'd93,
        8'd98,  8'd105, 8'd110, 8'd117, 8'd122, 8'd129, 8'd134, 8'd141,
        8'd3,   8'd8,   8'd15,  8'd20,  8'd27,  8'd32,  8'd39,  8'd44,
        8'd51,  8'd56,  8'd63,  8'd68,  8'd75,  8'd80,  8'd87,  8'd92,
        8'd99,  8'd104, 8'd111, 8'd116, 8'd123, 8'd128, 8'd135, 8'd140,
        8'd4,   8'd11,  8'd16,  8'd23,  8'd28,  8'd35,  8'd40,  8'd47,
        8'd52,  8'd59,  8'd64,  8'd71,  8'd76,  8'd83,  8'd88,  8'd95,
        8'd100, 8'd107, 8'd112, 8'd119, 8'd124, 8'd131, 8'd136, 8'd143,
        8'd5,   8'd10,  8'd17,  8'd22,  8'd29,  8'd34,  8'd41,  8'd46,
        8'd53,  8'd58,  8'd65,  8'd70,  8'd77,  8'd82,  8'd89,  8'd94,
        8'd101, 8'd106, 8'd113, 8'd118, 8'd125, 8'd130, 8'd137, 8'd142
    };

endpackage

### rtl/imbe_fdd_deint.sv
// Deinterleaver: reorders the codeword and seeds the descrambling chain.
module imbe_fdd_deint (
    input  logic [imbe_fdd_pkg::FIELD_BITS-1:0] frame_bits_0_to_47,
    input  logic [imbe_fdd_pkg::FIELD_BITS-1:0] frame_bits_48_to_95,
    input  logic [imbe_fdd_pkg::FIELD_BITS-1:0] frame_bits_96_to_143,
    output imbe_fdd_pkg::cell_data_t            cell_data
);

    logic [imbe_fdd_pkg::FRAME_BITS-1:0] codeword;
    logic [imbe_fdd_pkg::FRAME_BITS-1:0] deint;

    assign codeword = {frame_bits_0_to_47, frame_bits_48_to_95, frame_bits_96_to_143};

    // Codeword bit n sits at codeword[143-n]; deinterleaved bit i goes to deint[143-i].
    always_comb begin
        for (int i = 0; i < imbe_fdd_pkg::FRAME_BITS; i++) begin
            deint[imbe_fdd_pkg::FRAME_BITS-1-i] =
                codeword[imbe_fdd_pkg::FRAME_BITS-1-int'(imbe_fdd_pkg::ILV[i])];
        end
    end

    always_comb begin
        cell_data.c0  = deint[imbe_fdd_pkg::FRAME_BITS-1 -: imbe_fdd_pkg::C0_BITS];
        cell_data.win = deint[imbe_fdd_pkg::FRAME_BITS-1-imbe_fdd_pkg::WIN_FIRST
                              -: imbe_fdd_pkg::WIN_BITS];
        cell_data.c7  = deint[imbe_fdd_pkg::C7_BITS-1:0];
        cell_data.lcg = {cell_data.c0, 4'b0000};
    end

endmodule

### rtl/imbe_fdd_cell.sv
// One descrambler cell: steps the generator once and whitens one window bit.
module imbe_fdd_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  imbe_fdd_pkg::cell_data_t in_data,
    output logic                     out_valid,
    output imbe_fdd_pkg::cell_data_t out_data
);

    logic                     valid_reg;
    imbe_fdd_pkg::cell_data_t data_reg;
    imbe_fdd_pkg::cell_data_t data_next;
    logic [imbe_fdd_pkg::LCG_BITS-1:0] lcg_step;

    assign lcg_step = imbe_fdd_pkg::LCG_BITS'(in_data.lcg * imbe_fdd_pkg::LCG_MUL
                                              + imbe_fdd_pkg::LCG_ADD);

    // The bit being whitened is always at the top of the window; the window then
    // rotates left so that the next position comes up. After a full chain it is
    // back in its original order.
    always_comb begin
        data_next     = in_data;
        data_next.lcg = lcg_step;
        data_next.win = {in_data.win[imbe_fdd_pkg::WIN_BITS-2:0],
                         in_data.win[imbe_fdd_pkg::WIN_BITS-1]
                         ^ lcg_step[imbe_fdd_pkg::LCG_BITS-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/imbe_frame_deinterleave_descramble.sv
// Top level: deinterleaver followed by a chain of 114 descrambler cells.
// An accepted input transaction passes through the register of every cell in turn.
// Throughput: one codeword per cycle; the chain of cells advances as a whole
// whenever the last cell is empty or its result is being taken.
// Reset: synchronous, active low; clears the valid bit of every cell, so the
// chain comes up empty and ready.
module imbe_frame_deinterleave_descramble (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [imbe_fdd_pkg::FIELD_BITS-1:0] s_frame_bits_0_to_47,
    input  logic [imbe_fdd_pkg::FIELD_BITS-1:0] s_frame_bits_48_to_95,
    input  logic [imbe_fdd_pkg::FIELD_BITS-1:0] s_frame_bits_96_to_143,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [11:0]                         m_vector_c0,
    output logic [11:0]                         m_vector_c1,
    output logic [11:0]                         m_vector_c2,
    output logic [11:0]                         m_vector_c3,
    output logic [10:0]                         m_vector_c4,
    output logic [10:0]                         m_vector_c5,
    output logic [10:0]                         m_vector_c6,
    output logic [6:0]                          m_vector_c7
);

    localparam int NCELLS = imbe_fdd_pkg::NUM_CELLS;

    logic                     advance;
    logic [NCELLS:0]          stage_valid;
    imbe_fdd_pkg::cell_data_t stage_data [NCELLS+1];
    imbe_fdd_pkg::cell_data_t result;

    assign advance        = !stage_valid[NCELLS] || m_ready;
    assign s_ready        = advance;
    assign stage_valid[0] = s_valid;

    imbe_fdd_deint u_deint (
        .frame_bits_0_to_47  (s_frame_bits_0_to_47),
        .frame_bits_48_to_95 (s_frame_bits_48_to_95),
        .frame_bits_96_to_143(s_frame_bits_96_to_143),
        .cell_data           (stage_data[0])
    );

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        imbe_fdd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (advance),
            .in_valid (stage_valid[g]),
            .in_data  (stage_data[g]),
            .out_valid(stage_valid[g+1]),
            .out_data (stage_data[g+1])
        );
    end

    assign result      = stage_data[NCELLS];
    assign m_valid     = stage_valid[NCELLS];
    assign m_vector_c0 = result.c0;
    assign m_vector_c1 = result.win[113:102];
    assign m_vector_c2 = result.win[90:79];
    assign m_vector_c3 = result.win[67:56];
    assign m_vector_c4 = result.win[44:34];
    assign m_vector_c5 = result.win[29:19];
    assign m_vector_c6 = result.win[14:4];
    assign m_vector_c7 = result.c7;

    // A stalled result must hold the whole chain, input side included.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while the result is stalled");

    // While stalled, no cell gains or loses a transaction.
    a_stall_freezes_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(stage_valid[NCELLS:1]))
        else $error("cell occupancy changed during a stall");

    // An accepted transaction lands in the first cell.
    a_accept_enters_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> stage_valid[1])
        else $error("accepted transaction missing from the first cell");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
